>>> rtl/four_level_page_table_walker_unit_macros.svh
// Assertion macros for the page table walker.
// Used by the top level only; no other dependencies.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH

// same-cycle implication
`define FPW_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("fpw check failed");

// next-cycle implication
`define FPW_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("fpw check failed");

`endif

>>> rtl/fpw_pkg.sv
// Shared types and constants for the page table walker.
// No dependencies; used by fpw_ctrl, fpw_datapath and the top level.
package fpw_pkg;

    localparam int TABLE_FRAMES_DEF  = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int SLOT_W            = 9;

    localparam logic [2:0] MODE_XLATE = 3'd0;
    localparam logic [2:0] MODE_MAP   = 3'd1;
    localparam logic [2:0] MODE_UNMAP = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNMAPPED = 2'd1;
    localparam logic [1:0] ST_NOFRAME  = 2'd2;
    localparam logic [1:0] ST_OUTSIDE  = 2'd3;

    localparam logic CFG_ROOT = 1'b0;
    localparam logic CFG_FREE = 1'b1;

    typedef enum logic [2:0] {
        WS_SWEEP = 3'd0,
        WS_LINK  = 3'd1,
        WS_WIDEN = 3'd2,
        WS_LEAF  = 3'd3,
        WS_UNMAP = 3'd4,
        WS_RAW   = 3'd5
    } wsel_t;

    typedef struct packed {
        logic       latch;
        logic       rd_walk;
        logic       rd_raw;
        logic       wr_en;
        wsel_t      wsel;
        logic       sweep_step;
        logic       alloc;
        logic       descend_mem;
        logic       descend_nf;
        logic       set_status;
        logic [1:0] status;
        logic       set_phys;
        logic       set_data;
        logic       set_inv;
        logic       out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       root_ok;
        logic       idx_ok;
        logic       present;
        logic       huge;
        logic       child_ok;
        logic       alloc_ok;
        logic       leaf_lvl;
        logic       last_lvl;
        logic       user_flag;
        logic       row_end;
        logic       all_end;
        logic       out_free;
    } ctl_sts_t;

endpackage

>>> rtl/fpw_ctrl.sv
// Walk sequencer for the page table walker.
// Depends on fpw_pkg; drives fpw_datapath through ctl_cmd_t.
module fpw_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fpw_pkg::ctl_sts_t sts,
    output fpw_pkg::ctl_cmd_t cmd
);

    typedef enum logic [9:0] {
        S_CLEAR    = 10'b0000000001,
        S_IDLE     = 10'b0000000010,
        S_DISPATCH = 10'b0000000100,
        S_RD       = 10'b0000001000,
        S_EVAL     = 10'b0000010000,
        S_ZERO     = 10'b0000100000,
        S_LINK     = 10'b0001000000,
        S_LEAF     = 10'b0010000000,
        S_RAWQ     = 10'b0100000000,
        S_DONE     = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        cmd.wsel   = fpw_pkg::WS_SWEEP;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_en      = 1'b1;
                cmd.sweep_step = 1'b1;
                if (sts.all_end)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                if (sts.mode == fpw_pkg::MODE_XLATE || sts.mode == fpw_pkg::MODE_MAP ||
                    sts.mode == fpw_pkg::MODE_UNMAP)
                begin
                    if (sts.root_ok)
                        state_next = S_RD;
                    else
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = fpw_pkg::ST_OUTSIDE;
                    end
                end
                else if (sts.mode == fpw_pkg::MODE_WRITE || sts.mode == fpw_pkg::MODE_READ)
                begin
                    if (!sts.idx_ok)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = fpw_pkg::ST_OUTSIDE;
                    end
                    else if (sts.mode == fpw_pkg::MODE_WRITE)
                    begin
                        cmd.wr_en = 1'b1;
                        cmd.wsel  = fpw_pkg::WS_RAW;
                    end
                    else
                    begin
                        cmd.rd_raw = 1'b1;
                        state_next = S_RAWQ;
                    end
                end
            end
            S_RD:
            begin
                cmd.rd_walk = 1'b1;
                state_next  = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_DONE;
                if (sts.leaf_lvl)
                begin
                    if (sts.mode == fpw_pkg::MODE_UNMAP)
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wsel    = fpw_pkg::WS_UNMAP;
                        cmd.set_inv = 1'b1;
                    end
                    else if (sts.present)
                        cmd.set_phys = 1'b1;
                    else
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = fpw_pkg::ST_UNMAPPED;
                    end
                end
                else if (sts.mode == fpw_pkg::MODE_MAP)
                begin
                    if (sts.huge)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = fpw_pkg::ST_UNMAPPED;
                    end
                    else if (!sts.present)
                    begin
                        if (sts.alloc_ok)
                        begin
                            cmd.alloc  = 1'b1;
                            state_next = S_ZERO;
                        end
                        else
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = fpw_pkg::ST_NOFRAME;
                        end
                    end
                    else
                    begin
                        // present table: widen user bit if requested, then descend if the child frame is in range
                        if (sts.user_flag)
                        begin
                            cmd.wr_en = 1'b1;
                            cmd.wsel  = fpw_pkg::WS_WIDEN;
                        end
                        if (!sts.child_ok)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = fpw_pkg::ST_OUTSIDE;
                        end
                        else
                        begin
                            cmd.descend_mem = 1'b1;
                            state_next      = sts.last_lvl ? S_LEAF : S_RD;
                        end
                    end
                end
                else if (!sts.present || sts.huge)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = fpw_pkg::ST_UNMAPPED;
                end
                else if (!sts.child_ok)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = fpw_pkg::ST_OUTSIDE;
                end
                else
                begin
                    cmd.descend_mem = 1'b1;
                    state_next      = S_RD;
                end
            end
            S_ZERO:
            begin
                cmd.wr_en      = 1'b1;
                cmd.sweep_step = 1'b1;
                if (sts.row_end)
                    state_next = S_LINK;
            end
            S_LINK:
            begin
                cmd.wr_en      = 1'b1;
                cmd.wsel       = fpw_pkg::WS_LINK;
                cmd.descend_nf = 1'b1;
                state_next     = sts.last_lvl ? S_LEAF : S_RD;
            end
            S_LEAF:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wsel   = fpw_pkg::WS_LEAF;
                state_next = S_DONE;
            end
            S_RAWQ:
            begin
                cmd.set_data = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/fpw_datapath.sv
// Table store, walk registers, allocator and result register.
// Depends on fpw_pkg; steered by fpw_ctrl through ctl_cmd_t.
module fpw_datapath #(
    parameter int TABLE_FRAMES = fpw_pkg::TABLE_FRAMES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [191:0]      in_data,
    input  logic              cfg_valid,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_data,
    input  fpw_pkg::ctl_cmd_t cmd,
    output fpw_pkg::ctl_sts_t sts,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [119:0]      out_data
);

    localparam int FW    = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int SW    = fpw_pkg::SLOT_W;
    localparam int AW    = FW + SW;
    localparam int DEPTH = TABLE_FRAMES * fpw_pkg::ENTRIES_PER_TABLE;
    localparam int NFW   = (FW + 1 > 7) ? FW + 1 : 7;

    logic [63:0]    mem [DEPTH];
    logic [63:0]    rd_data_reg;

    logic [5:0]     root_reg;
    logic [NFW-1:0] next_free_reg;
    logic [AW-1:0]  sweep_reg;
    logic           out_valid_reg;
    logic [119:0]   out_data_reg;

    logic [2:0]     mode_reg;
    logic [47:0]    va_reg;
    logic [51:0]    pa_reg;
    logic [2:0]     flags_reg;
    logic [14:0]    idx_reg;
    logic [63:0]    val_reg;
    logic [FW-1:0]  fr_reg;
    logic [1:0]     lvl_reg;
    logic [FW-1:0]  nf_reg;
    logic [51:0]    res_phys_reg;
    logic [63:0]    res_data_reg;
    logic [1:0]     res_status_reg;
    logic           res_inv_reg;

    logic [SW-1:0]  slot;
    logic [AW-1:0]  walk_addr;
    logic [AW-1:0]  wr_addr;
    logic [63:0]    wr_data;
    logic [AW-1:0]  rd_addr;

    always_comb
    begin
        case (lvl_reg)
            2'd3:    slot = va_reg[47:39];
            2'd2:    slot = va_reg[38:30];
            2'd1:    slot = va_reg[29:21];
            default: slot = va_reg[20:12];
        endcase
    end

    assign walk_addr = {fr_reg, slot};
    assign rd_addr   = cmd.rd_raw ? AW'(idx_reg) : walk_addr;

    always_comb
    begin
        wr_addr = walk_addr;
        wr_data = '0;
        case (cmd.wsel)
            fpw_pkg::WS_SWEEP: wr_addr = sweep_reg;
            fpw_pkg::WS_LINK:
                wr_data = {12'd0, 40'(nf_reg), 9'd0, flags_reg[2], 2'b11};
            fpw_pkg::WS_WIDEN: wr_data = rd_data_reg | 64'h4;
            fpw_pkg::WS_LEAF:  wr_data = {12'd0, pa_reg[51:12], 9'd0, flags_reg};
            fpw_pkg::WS_UNMAP: wr_data = '0;
            fpw_pkg::WS_RAW:
            begin
                wr_addr = AW'(idx_reg);
                wr_data = val_reg;
            end
            default: wr_data = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_walk || cmd.rd_raw)
            rd_data_reg <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg      <= '0;
            next_free_reg <= NFW'(1);
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == fpw_pkg::CFG_ROOT)
                root_reg <= cfg_data[5:0];
            if (cfg_valid && cfg_index == fpw_pkg::CFG_FREE)
                next_free_reg <= NFW'(cfg_data);
            else if (cmd.alloc)
                next_free_reg <= next_free_reg + NFW'(1);
            if (cmd.alloc)
                sweep_reg <= {next_free_reg[FW-1:0], {SW{1'b0}}};
            else if (cmd.sweep_step)
                sweep_reg <= sweep_reg + AW'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // request and walk payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg       <= in_data[2:0];
            va_reg         <= in_data[50:3];
            pa_reg         <= in_data[102:51];
            flags_reg      <= in_data[105:103];
            idx_reg        <= in_data[120:106];
            val_reg        <= in_data[184:121];
            fr_reg         <= FW'(root_reg);
            lvl_reg        <= 2'd3;
            res_phys_reg   <= '0;
            res_data_reg   <= '0;
            res_status_reg <= fpw_pkg::ST_OK;
            res_inv_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.descend_mem)
            begin
                fr_reg  <= rd_data_reg[12 +: FW];
                lvl_reg <= lvl_reg - 2'd1;
            end
            else if (cmd.descend_nf)
            begin
                fr_reg  <= nf_reg;
                lvl_reg <= lvl_reg - 2'd1;
            end
            if (cmd.set_status)
                res_status_reg <= cmd.status;
            if (cmd.set_phys)
                res_phys_reg <= {rd_data_reg[51:12], va_reg[11:0]};
            if (cmd.set_data)
                res_data_reg <= rd_data_reg;
            if (cmd.set_inv)
                res_inv_reg <= 1'b1;
        end
        if (cmd.alloc)
            nf_reg <= next_free_reg[FW-1:0];
        if (cmd.out_load)
            out_data_reg <= {1'b0, res_inv_reg, res_status_reg, res_data_reg, res_phys_reg};
    end

    assign sts.mode      = mode_reg;
    assign sts.root_ok   = 32'(root_reg) < TABLE_FRAMES;
    assign sts.idx_ok    = 32'(idx_reg) < DEPTH;
    assign sts.present   = rd_data_reg[0];
    assign sts.huge      = rd_data_reg[7];
    assign sts.child_ok  = rd_data_reg[51:12] < 40'(TABLE_FRAMES);
    assign sts.alloc_ok  = 32'(next_free_reg) < TABLE_FRAMES;
    assign sts.leaf_lvl  = (lvl_reg == 2'd0);
    assign sts.last_lvl  = (lvl_reg == 2'd1);
    assign sts.user_flag = flags_reg[2];
    assign sts.row_end   = &sweep_reg[SW-1:0];
    assign sts.all_end   = (sweep_reg == AW'(DEPTH - 1));
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/four_level_page_table_walker_unit.sv
// Four-level page table walker with on-chip table store: top level.
// Depends on fpw_pkg, fpw_ctrl, fpw_datapath and the assertion macro header.
//
// Usage: one request enters on s_axis (tdata fields below), one result leaves
// on m_axis. Configuration goes over cfg_valid/cfg_index/cfg_data while idle:
// index 0 sets the root table frame, index 1 reloads the frame allocator.
// Requests are worked one at a time through a single-port table store with a
// registered read; each level takes an address step and an evaluate step.
// Map creates each missing table with a 512-entry zero sweep and a link write.
// A result sits in the output register while the next request is accepted.
// If m_axis stalls, the walker finishes its request and holds in its done
// state until the output register frees.
// After reset the store is cleared one entry per cycle, all TABLE_FRAMES*512
// entries (32768 by default); s_axis_tready stays low until that ends.
module four_level_page_table_walker_unit #(
    parameter int TABLE_FRAMES = fpw_pkg::TABLE_FRAMES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[2:0], virt_addr[50:3], phys_addr[102:51], map_flags[105:103],
    // entry_index[120:106], entry_value[184:121], zero fill
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // phys_result[51:0], entry_data[115:52], status[117:116],
    // invalidate_request[118], zero fill
    output logic [119:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [6:0]   cfg_data
);

`include "four_level_page_table_walker_unit_macros.svh"

    fpw_pkg::ctl_cmd_t cmd;
    fpw_pkg::ctl_sts_t sts;

    assign cfg_ready = 1'b1;

    fpw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fpw_datapath #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    `FPW_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `FPW_ASSERT_NOW(a_alloc_in_range, clk, rst_n, cmd.alloc, sts.alloc_ok)
    `FPW_ASSERT_NOW(a_raw_in_range, clk, rst_n, cmd.wr_en && cmd.wsel == fpw_pkg::WS_RAW, sts.idx_ok)
    `FPW_ASSERT_NEXT(a_result_shown, clk, rst_n, cmd.out_load, m_axis_tvalid)

endmodule
